FILE: src/icmp_reply_matcher_macros.svh
// assertion macros for the icmp reply matcher checker
// used by the checker file only, no other dependencies
`ifndef ICMP_REPLY_MATCHER_MACROS_SVH
`define ICMP_REPLY_MATCHER_MACROS_SVH

// clocked check, masked while reset is held
`define IRM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("icmp_reply_matcher check failed");

// clocked check that also runs through reset
`define IRM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("icmp_reply_matcher reset check failed");

`endif

FILE: src/icmp_rm_pkg.sv
// shared types and constants for the icmp reply matcher
// no dependencies
package icmp_rm_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  message_type;
    logic        checksum_ok;
    logic [15:0] found_id;
    logic [15:0] found_seq;
  } out_beat_t;

  typedef enum logic [2:0] {
    KIND_ECHO      = 3'd0,
    KIND_UNREACH   = 3'd1,
    KIND_TIMEX     = 3'd2,
    KIND_MISMATCH  = 3'd3,
    KIND_UNHANDLED = 3'd4,
    KIND_SHORT     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_ECHO  = 2'd1,
    CLS_ERROR = 2'd2,
    CLS_OTHER = 2'd3
  } cls_t;

  // control from the parser to the checksum unit
  typedef struct packed {
    logic       add_en;
    logic       finish;
    logic [7:0] data_byte;
  } csum_ctrl_t;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_IP_MODE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXP_ID   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXP_SEQ  = 2'd2;

  localparam logic [7:0] T4_ECHO_REPLY = 8'd0;
  localparam logic [7:0] T4_UNREACH    = 8'd3;
  localparam logic [7:0] T4_TIMEX      = 8'd11;
  localparam logic [7:0] T6_ECHO_REPLY = 8'd129;
  localparam logic [7:0] T6_UNREACH    = 8'd1;
  localparam logic [7:0] T6_TIMEX      = 8'd3;

  localparam int ECHO_HDR_LEN = 8;
  localparam int ERR_HDR_LEN  = 8;
  localparam int IP4_HDR_MIN  = 20;
  localparam int V4_MIN_LEN   = IP4_HDR_MIN + ECHO_HDR_LEN;
  localparam int ERR_MIN_LEN  = IP4_HDR_MIN * 2 + ECHO_HDR_LEN * 2;
  localparam int V6_MIN_LEN   = 8;
  localparam int V6_ECHO_OFS  = 48;

endpackage

FILE: src/icmp_reply_matcher.sv
// top level of the icmp reply matcher: input stage, config registers, result register
// depends on icmp_rm_pkg, icmp_rm_parse and icmp_rm_csum
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | in_data (data_byte, last_byte)
//   out_    | output    | out_valid/out_stall | out_data (one beat per packet)
//   cfg_    | input     | cfg_we            | cfg_addr, cfg_wdata
//
// one byte is taken per cycle unless in_stall is high; a byte is parsed from s1_r
// the result beat appears the cycle after the last byte is parsed
// a waiting result only holds back the next last byte, other bytes keep flowing
// reset is synchronous and clears config, parser state and both valid flags
module icmp_reply_matcher #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  icmp_rm_pkg::in_beat_t                in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output icmp_rm_pkg::out_beat_t               out_data,
  input  logic                                 cfg_we,
  input  logic [icmp_rm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [icmp_rm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic                    ip_mode_r;
  logic [15:0]             exp_id_r, exp_seq_r;
  logic                    s1_valid_r;
  icmp_rm_pkg::in_beat_t   s1_r;
  logic                    out_valid_r;
  icmp_rm_pkg::out_beat_t  out_data_r;
  logic                    proceed, sum_ok;
  icmp_rm_pkg::csum_ctrl_t csum_ctrl;
  icmp_rm_pkg::out_beat_t  res;

  assign proceed  = s1_valid_r && (!s1_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !proceed;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_mode_r <= 1'b0;
      exp_id_r  <= '0;
      exp_seq_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        icmp_rm_pkg::CFG_IP_MODE: ip_mode_r <= cfg_wdata[0];
        icmp_rm_pkg::CFG_EXP_ID:  exp_id_r  <= cfg_wdata;
        icmp_rm_pkg::CFG_EXP_SEQ: exp_seq_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed && s1_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (proceed && s1_r.last_byte) begin
      out_data_r <= res;
    end
  end

  icmp_rm_parse #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proceed),
    .beat      (s1_r),
    .ip_mode   (ip_mode_r),
    .exp_id    (exp_id_r),
    .exp_seq   (exp_seq_r),
    .sum_ok    (sum_ok),
    .csum_ctrl (csum_ctrl),
    .res       (res)
  );

  icmp_rm_csum u_csum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (csum_ctrl),
    .sum_ok (sum_ok)
  );

endmodule

FILE: src/icmp_rm_csum.sv
// one's-complement checksum accumulator over the icmp part
// depends on icmp_rm_pkg
module icmp_rm_csum (
  input  logic                    clk,
  input  logic                    rst_n,
  input  icmp_rm_pkg::csum_ctrl_t ctrl,
  output logic                    sum_ok
);

  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        hold_vld_r, hold_vld_nxt;
  logic [15:0] final_sum;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

  always_comb begin
    sum_nxt      = sum_r;
    hold_nxt     = hold_r;
    hold_vld_nxt = hold_vld_r;
    if (ctrl.add_en) begin
      if (hold_vld_r) begin
        sum_nxt      = ones_add(sum_r, {hold_r, ctrl.data_byte});
        hold_vld_nxt = 1'b0;
      end else begin
        hold_nxt     = ctrl.data_byte;
        hold_vld_nxt = 1'b1;
      end
    end
    // odd trailing byte padded with a zero low byte
    final_sum = hold_vld_nxt ? ones_add(sum_nxt, {hold_nxt, 8'h00}) : sum_nxt;
    sum_ok    = (final_sum == 16'hFFFF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.finish) begin
      sum_r      <= '0;
      hold_r     <= '0;
      hold_vld_r <= 1'b0;
    end else begin
      sum_r      <= sum_nxt;
      hold_r     <= hold_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
  end

endmodule

FILE: src/icmp_rm_parse.sv
// byte position tracking, type classification, id/seq capture and result forming
// depends on icmp_rm_pkg
module icmp_rm_parse #(
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  icmp_rm_pkg::in_beat_t   beat,
  input  logic                    ip_mode,
  input  logic [15:0]             exp_id,
  input  logic [15:0]             exp_seq,
  input  logic                    sum_ok,
  output icmp_rm_pkg::csum_ctrl_t csum_ctrl,
  output icmp_rm_pkg::out_beat_t  res
);

  localparam int CW = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [5:0]            icmp_start_r, icmp_start_nxt, icmp_start_e;
  logic [7:0]            echo_start_r, echo_start_nxt;
  logic [7:0]            type_r, type_nxt;
  icmp_rm_pkg::cls_t     cls_r, cls_nxt;
  logic [15:0]           id_r, id_nxt;
  logic [15:0]           seq_r, seq_nxt;
  logic                  found_r, found_nxt;

  logic                  take, v6, at_type, is_echo, is_err, short_pkt;
  logic [7:0]            b;
  logic [CW-1:0]         pos_x, ist_x, echo_x, off_x, len_x, echo_end_x;
  icmp_rm_pkg::kind_t    kind;

  always_comb begin
    v6   = ip_mode;
    b    = beat.data_byte;
    take = step && (cnt_r != COUNT_MAX);

    icmp_start_e = (cnt_r == '0) ? (v6 ? 6'd0 : {b[3:0], 2'b00}) : icmp_start_r;
    pos_x   = CW'(cnt_r);
    ist_x   = CW'(icmp_start_e);
    echo_x  = CW'(echo_start_r);
    off_x   = pos_x - echo_x;
    at_type = (pos_x == ist_x);

    is_echo = v6 ? (b == icmp_rm_pkg::T6_ECHO_REPLY) : (b == icmp_rm_pkg::T4_ECHO_REPLY);
    is_err  = v6 ? (b == icmp_rm_pkg::T6_UNREACH || b == icmp_rm_pkg::T6_TIMEX)
                 : (b == icmp_rm_pkg::T4_UNREACH || b == icmp_rm_pkg::T4_TIMEX);

    cnt_nxt        = cnt_r;
    icmp_start_nxt = icmp_start_r;
    echo_start_nxt = echo_start_r;
    type_nxt       = type_r;
    cls_nxt        = cls_r;
    id_nxt         = id_r;
    seq_nxt        = seq_r;
    found_nxt      = found_r;

    if (take) begin
      cnt_nxt        = cnt_r + 1'b1;
      icmp_start_nxt = icmp_start_e;

      if (at_type) begin
        type_nxt = b;
        if (is_echo) begin
          cls_nxt        = icmp_rm_pkg::CLS_ECHO;
          echo_start_nxt = 8'(icmp_start_e);
          found_nxt      = 1'b1;
        end else if (is_err) begin
          cls_nxt = icmp_rm_pkg::CLS_ERROR;
          if (v6) begin
            echo_start_nxt = 8'(icmp_start_e) + 8'(icmp_rm_pkg::V6_ECHO_OFS);
            found_nxt      = 1'b1;
          end
        end else begin
          cls_nxt = icmp_rm_pkg::CLS_OTHER;
        end
      end

      // inner ipv4 header of a quoted datagram
      if (!v6 && cls_r == icmp_rm_pkg::CLS_ERROR && !found_r &&
          pos_x == ist_x + CW'(icmp_rm_pkg::ERR_HDR_LEN)) begin
        echo_start_nxt = 8'(pos_x + CW'({b[3:0], 2'b00}));
        found_nxt      = 1'b1;
      end

      if (found_r && pos_x >= echo_x) begin
        if (off_x == CW'(4) || off_x == CW'(5)) begin
          id_nxt = {id_r[7:0], b};
        end else if (off_x == CW'(6) || off_x == CW'(7)) begin
          seq_nxt = {seq_r[7:0], b};
        end
      end
    end

    csum_ctrl.add_en    = take && (pos_x >= ist_x);
    csum_ctrl.finish    = step && beat.last_byte;
    csum_ctrl.data_byte = b;

    len_x      = CW'(cnt_nxt);
    echo_end_x = CW'(echo_start_nxt) + CW'(icmp_rm_pkg::ECHO_HDR_LEN);
    short_pkt  = (len_x < (v6 ? CW'(icmp_rm_pkg::V6_MIN_LEN) : CW'(icmp_rm_pkg::V4_MIN_LEN))) ||
                 (cls_nxt == icmp_rm_pkg::CLS_NONE);

    priority if (short_pkt) begin
      kind = icmp_rm_pkg::KIND_SHORT;
    end else if (cls_nxt == icmp_rm_pkg::CLS_OTHER) begin
      kind = icmp_rm_pkg::KIND_UNHANDLED;
    end else if (cls_nxt == icmp_rm_pkg::CLS_ERROR &&
                 len_x < CW'(icmp_rm_pkg::ERR_MIN_LEN)) begin
      kind = icmp_rm_pkg::KIND_SHORT;
    end else if (!found_nxt || len_x < echo_end_x) begin
      kind = icmp_rm_pkg::KIND_SHORT;
    end else if (id_nxt != exp_id || seq_nxt != exp_seq) begin
      kind = icmp_rm_pkg::KIND_MISMATCH;
    end else if (cls_nxt == icmp_rm_pkg::CLS_ECHO) begin
      kind = icmp_rm_pkg::KIND_ECHO;
    end else if (type_nxt == (v6 ? icmp_rm_pkg::T6_UNREACH : icmp_rm_pkg::T4_UNREACH)) begin
      kind = icmp_rm_pkg::KIND_UNREACH;
    end else begin
      kind = icmp_rm_pkg::KIND_TIMEX;
    end

    res.result_kind  = kind;
    res.message_type = type_nxt;
    res.checksum_ok  = v6 || sum_ok;
    res.found_id     = (kind <= icmp_rm_pkg::KIND_MISMATCH) ? id_nxt : 16'd0;
    res.found_seq    = (kind <= icmp_rm_pkg::KIND_MISMATCH) ? seq_nxt : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && beat.last_byte)) begin
      cnt_r        <= '0;
      icmp_start_r <= '0;
      echo_start_r <= '0;
      type_r       <= '0;
      cls_r        <= icmp_rm_pkg::CLS_NONE;
      id_r         <= '0;
      seq_r        <= '0;
      found_r      <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      icmp_start_r <= icmp_start_nxt;
      echo_start_r <= echo_start_nxt;
      type_r       <= type_nxt;
      cls_r        <= cls_nxt;
      id_r         <= id_nxt;
      seq_r        <= seq_nxt;
      found_r      <= found_nxt;
    end
  end

endmodule

FILE: src/icmp_rm_checker.sv
// port-level checks for the icmp reply matcher, bound to the top level
// depends on icmp_rm_pkg and icmp_reply_matcher_macros.svh
`include "icmp_reply_matcher_macros.svh"

module icmp_rm_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input icmp_rm_pkg::in_beat_t  in_data,
  input logic                   out_valid,
  input logic                   out_stall,
  input icmp_rm_pkg::out_beat_t out_data
);

  logic last_taken;
  logic no_id_kind;
  logic ids_zero;

  assign last_taken = in_valid && !in_stall && in_data.last_byte;
  assign no_id_kind = (out_data.result_kind == icmp_rm_pkg::KIND_UNHANDLED) ||
                      (out_data.result_kind == icmp_rm_pkg::KIND_SHORT);
  assign ids_zero   = (out_data.found_id == 16'd0) && (out_data.found_seq == 16'd0);

  // no result beat straight after reset
  `IRM_ASSERT_RST(a_no_out_after_rst, !rst_n |=> !out_valid)

  // stalled result beat holds
  `IRM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))

  // ids are blanked for unhandled and short packets
  `IRM_ASSERT(a_blank_ids, out_valid && no_id_kind |-> ids_zero)

  // a fresh result follows a last byte taken at the input
  `IRM_ASSERT(a_out_from_last, $rose(out_valid) |-> $past(last_taken, 2))

endmodule

bind icmp_reply_matcher icmp_rm_checker u_icmp_rm_checker (.*);
